FILE: rtl/eaet_pkg.sv
// Shared types and constants for the echo-average edge trigger.
package eaet_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SAMPLES = 2'd0,
        CFG_NEAR    = 2'd1,
        CFG_INVALID = 2'd2,
        CFG_TRIGGER = 2'd3
    } cfg_index_t;

    // Configuration register file as seen by the datapath
    typedef struct packed {
        logic [3:0]  samples_per_group;
        logic [15:0] near_limit_ticks;
        logic [15:0] invalid_limit_ticks;
        logic [3:0]  trigger_needed;
    } cfg_t;

    localparam logic [3:0]  SAMPLES_RST = 4'd5;
    localparam logic [15:0] NEAR_RST    = 16'd1457;
    localparam logic [15:0] INVALID_RST = 16'd58251;
    localparam logic [3:0]  TRIGGER_RST = 4'd3;

    // Drive orders
    typedef enum logic [1:0] {
        DRIVE_FORWARD = 2'd0,
        DRIVE_KEEP    = 2'd1,
        DRIVE_TURN    = 2'd2
    } drive_action_t;

    // Back-end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

endpackage

FILE: rtl/eaet_in_if.sv
// Sample channel: one echo measurement per transaction.
interface eaet_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] echo_ticks;
    logic        echo_missing;

    modport source (output valid, output echo_ticks, output echo_missing, input ready);
    modport sink   (input valid, input echo_ticks, input echo_missing, output ready);
endinterface

FILE: rtl/eaet_out_if.sv
// Result channel: one group decision per transaction.
interface eaet_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] mean_ticks;
    logic        group_has_valid;
    logic [3:0]  edge_count;
    logic [1:0]  drive_action;

    modport source (output valid, output mean_ticks, output group_has_valid,
                    output edge_count, output drive_action, input ready);
    modport sink   (input valid, input mean_ticks, input group_has_valid,
                    input edge_count, input drive_action, output ready);
endinterface

FILE: rtl/eaet_cfg_if.sv
// Configuration write channel: register index and write data.
interface eaet_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/eaet_front.sv
// Front end: qualify samples, accumulate the group, push group totals.
module eaet_front
    import eaet_pkg::*;
#(
    parameter int MAX_GROUP = 8,
    parameter int TICK_BITS = 16,
    parameter int SUM_W     = 19,
    parameter int CNT_W     = 4,
    parameter int IDX_W     = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    eaet_in_if.sink          samples,
    input  cfg_t             cfg,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [SUM_W-1:0] push_sum,
    output logic [CNT_W-1:0] push_cnt
);

    localparam logic [15:0] TICK_MASK =
        (TICK_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << TICK_BITS) - 32'd1);
    localparam logic [4:0]  MAX_G = 5'(MAX_GROUP);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next, sum_add;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_add;
    logic [15:0]      ticks;
    logic [4:0]       spg;
    logic [4:0]       gsize;
    logic [4:0]       idx_plus;
    logic             sample_ok;
    logic             is_last;
    logic             take;

    assign ticks     = samples.echo_ticks & TICK_MASK;
    assign sample_ok = !samples.echo_missing && (ticks < cfg.invalid_limit_ticks);

    // Clamp group size into 1..MAX_GROUP
    assign spg = {1'b0, cfg.samples_per_group};
    always_comb
    begin
        if (spg == 5'd0)
        begin
            gsize = 5'd1;
        end
        else if (spg > MAX_G)
        begin
            gsize = MAX_G;
        end
        else
        begin
            gsize = spg;
        end
    end

    assign idx_plus = 5'(idx_reg) + 5'd1;
    assign is_last  = (idx_plus >= gsize);

    assign sum_add = sum_reg + (sample_ok ? SUM_W'(ticks) : '0);
    assign cnt_add = cnt_reg + CNT_W'(sample_ok);

    // Stall only the closing sample of a group on a full queue
    assign samples.ready = !is_last || push_ready;
    assign take          = samples.valid && samples.ready;

    assign push_valid = samples.valid && is_last;
    assign push_sum   = sum_add;
    assign push_cnt   = cnt_add;

    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            if (is_last)
            begin
                idx_next = '0;
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
                sum_next = sum_add;
                cnt_next = cnt_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/eaet_fifo.sv
// Two-entry queue between front and back end.
module eaet_fifo #(
    parameter int W = 23
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push;
    logic         do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/eaet_div.sv
// Restoring divider, two quotient bits per cycle, narrow divisor.
module eaet_div #(
    parameter int SUM_W = 19,
    parameter int CNT_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             busy,
    output logic [15:0]      quotient
);

    localparam int STEPS = (SUM_W + 1) / 2;
    localparam int DW    = 2 * STEPS;
    localparam int SW    = $clog2(STEPS + 1);

    logic [DW-1:0]    work_reg, work_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg;
    logic [SW-1:0]    step_reg, step_next;
    logic [CNT_W:0]   trial;

    assign busy     = (step_reg != '0);
    assign quotient = work_reg[15:0];

    // Two shift-subtract steps per cycle; quotient bits enter at the bottom
    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        trial     = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial     = {rem_next, work_next[DW-1]};
            work_next = {work_next[DW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next     = CNT_W'(trial - {1'b0, dvs_reg});
                work_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (start)
        begin
            step_next = SW'(STEPS);
        end
        else if (busy)
        begin
            step_next = step_reg - SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= DW'(dividend);
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/eaet_back.sv
// Back end: divide group totals, decide drive order, hold the result.
module eaet_back
    import eaet_pkg::*;
#(
    parameter int SUM_W = 19,
    parameter int CNT_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  logic [SUM_W-1:0] pop_sum,
    input  logic [CNT_W-1:0] pop_cnt,
    input  cfg_t             cfg,
    eaet_out_if.source       results
);

    back_state_t   state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [3:0]    consec_reg, consec_next;
    logic          out_valid_reg, out_valid_next;
    logic [15:0]   mean_reg;
    logic          has_valid_reg;
    logic [3:0]    edge_reg;
    drive_action_t action_reg;

    logic          div_start;
    logic          div_busy;
    logic [15:0]   quotient;
    logic          out_free;
    logic          emit;
    logic          has_valid;
    logic [15:0]   mean;
    logic          is_edge;
    logic [3:0]    consec_inc;
    drive_action_t action;

    eaet_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pop_sum),
        .divisor  (pop_cnt),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready = (state_reg == BK_IDLE);
        div_start = (state_reg == BK_IDLE) && pop_valid;
        emit      = (state_reg == BK_EMIT) && out_free;
    end

    // Group decision
    always_comb
    begin
        has_valid  = (cnt_reg != '0);
        mean       = has_valid ? quotient : 16'd0;
        is_edge    = has_valid && (mean > cfg.near_limit_ticks)
                     && (mean < cfg.invalid_limit_ticks);
        consec_inc = consec_reg + 4'd1;
        if (is_edge)
        begin
            if (consec_inc >= cfg.trigger_needed)
            begin
                action      = DRIVE_TURN;
                consec_next = 4'd0;
            end
            else
            begin
                action      = DRIVE_KEEP;
                consec_next = consec_inc;
            end
        end
        else
        begin
            action      = DRIVE_FORWARD;
            consec_next = 4'd0;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            cnt_reg <= pop_cnt;
        end
        if (emit)
        begin
            mean_reg      <= mean;
            has_valid_reg <= has_valid;
            edge_reg      <= consec_next;
            action_reg    <= action;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            consec_reg    <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                consec_reg <= consec_next;
            end
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.mean_ticks      = mean_reg;
    assign results.group_has_valid = has_valid_reg;
    assign results.edge_count      = edge_reg;
    assign results.drive_action    = action_reg;

endmodule

FILE: rtl/echo_average_edge_trigger.sv
// Throughput: one sample per cycle inside a group; the back end divides one group at a time
// with the two-bit-per-cycle divider and takes the next group only after emitting the result.
// A two-entry queue lets the front keep taking samples while a group divides.
// Reset (rst_n low, asynchronous): group state, edge count and queue clear,
// registers return to 5 / 1457 / 58251 / 3.
module echo_average_edge_trigger
    import eaet_pkg::*;
#(
    parameter int MAX_GROUP = 8,
    parameter int TICK_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    eaet_in_if.sink    samples,
    eaet_out_if.source results,
    eaet_cfg_if.sink   cfg
);

    // Sum of up to MAX_GROUP sixteen-bit samples, and a count up to MAX_GROUP
    localparam int SUM_W = 16 + $clog2(MAX_GROUP);
    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    cfg_t             cfg_reg, cfg_next;
    logic             push_valid;
    logic             push_ready;
    logic [SUM_W-1:0] push_sum;
    logic [CNT_W-1:0] push_cnt;
    logic             pop_valid;
    logic             pop_ready;
    logic [SUM_W-1:0] pop_sum;
    logic [CNT_W-1:0] pop_cnt;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_SAMPLES: cfg_next.samples_per_group   = cfg.data[3:0];
                CFG_NEAR:    cfg_next.near_limit_ticks    = cfg.data;
                CFG_INVALID: cfg_next.invalid_limit_ticks = cfg.data;
                CFG_TRIGGER: cfg_next.trigger_needed      = cfg.data[3:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_group   <= SAMPLES_RST;
            cfg_reg.near_limit_ticks    <= NEAR_RST;
            cfg_reg.invalid_limit_ticks <= INVALID_RST;
            cfg_reg.trigger_needed      <= TRIGGER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: qualify each sample and accumulate; push totals at group end
    eaet_front #(
        .MAX_GROUP (MAX_GROUP),
        .TICK_BITS (TICK_BITS),
        .SUM_W     (SUM_W),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sum   (push_sum),
        .push_cnt   (push_cnt)
    );

    // Queue: hold group totals while the back end is busy
    eaet_fifo #(
        .W (SUM_W + CNT_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_sum, push_cnt}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   ({pop_sum, pop_cnt})
    );

    // Back: divide, track consecutive edge groups, drive the result register
    eaet_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_sum   (pop_sum),
        .pop_cnt   (pop_cnt),
        .cfg       (cfg_reg),
        .results   (results)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the echo-average edge trigger: directed table, then random groups.
module testbench;
    import eaet_pkg::*;

    localparam int MAX_GROUP      = 8;
    // Quiet time that wait_for_drain allows after the last owed decision, for samples in flight.
    localparam int SETTLE_CYCLES  = 40;
    // Longest quiet stretch that a correct run can show, many times over.
    localparam int STALL_LIMIT    = 3000;
    localparam int ITEMS_PER_MODE = 650;
    localparam int REPORT_LIMIT   = 10;

    // One group decision as it leaves the block.
    typedef struct packed {
        logic [15:0]   mean_ticks;
        logic          group_has_valid;
        logic [3:0]    edge_count;
        drive_action_t drive_action;
    } decision_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // One line of the directed table: a sample or a register write. A sample row may carry
    // a decision typed in by hand; the decision then replaces the predicted one.
    typedef struct {
        row_kind_t   kind;
        cfg_index_t  index;
        logic [15:0] value;
        logic        missing;
        logic        typed;
        decision_t   want;
    } row_t;

    logic clk;
    logic rst_n;

    eaet_in_if  sample_ch ();
    eaet_out_if result_ch ();
    eaet_cfg_if cfg_ch ();

    echo_average_edge_trigger i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // Shadow of the registers and of the group accumulator.
    cfg_t        shadow_cfg;
    logic [2:0]  group_pos;
    logic [18:0] group_sum;
    logic [3:0]  group_valid;
    logic [3:0]  edge_run;

    // Decisions owed by the block, oldest first.
    decision_t pending_decisions[$];
    row_t      stimulus_table[$];

    int fault_count;
    int stall_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    // 20 ns period: low half, then high half.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor: fold one accepted sample into the group. Return 1 and the
    // decision when the sample closes the group, else 0.
    // ------------------------------------------------------------------
    function automatic bit average_echo(input logic [15:0] ticks, input logic missing,
                                        output decision_t d);
        int group_len;
        int mean;
        group_len = int'(shadow_cfg.samples_per_group);
        // A size of zero behaves as one; sizes past the maximum clamp to it.
        if (group_len == 0)
            group_len = 1;
        if (group_len > MAX_GROUP)
            group_len = MAX_GROUP;
        // Count only samples whose echo began and stayed under the invalid limit.
        if (!missing && ticks < shadow_cfg.invalid_limit_ticks)
        begin
            group_sum   += 19'(ticks);
            group_valid += 4'd1;
        end
        // Mid-group: advance the index and owe nothing. A size lowered mid-group closes
        // the group at the first sample whose index reaches the new size minus one.
        if (int'(group_pos) + 1 < group_len)
        begin
            group_pos += 3'd1;
            return 1'b0;
        end
        mean = (group_valid != 0) ? int'(group_sum / group_valid) : 0;
        d.mean_ticks      = mean[15:0];
        d.group_has_valid = (group_valid != 0);
        if (group_valid != 0 && mean > shadow_cfg.near_limit_ticks
            && mean < shadow_cfg.invalid_limit_ticks)
        begin
            // Edge group: count it and turn around once enough have been seen in a row.
            // A trigger of zero is met by the first edge group.
            edge_run += 4'd1;
            if (edge_run >= shadow_cfg.trigger_needed)
            begin
                d.drive_action = DRIVE_TURN;
                edge_run       = '0;
            end
            else
                d.drive_action = DRIVE_KEEP;
        end
        else
        begin
            // Near, out of range or no valid sample: clear the run and drive forward.
            edge_run       = '0;
            d.drive_action = DRIVE_FORWARD;
        end
        d.edge_count = edge_run;
        group_pos    = '0;
        group_sum    = '0;
        group_valid  = '0;
        return 1'b1;
    endfunction

    // Draw echo ticks that suit the current limits: mostly inside the edge band so that
    // runs of edge groups build up, the rest near, invalid or anywhere.
    function automatic logic [15:0] echo_for_setting();
        int lo;
        int hi;
        int pick;
        lo   = int'(shadow_cfg.near_limit_ticks) + 1;
        hi   = int'(shadow_cfg.invalid_limit_ticks) - 1;
        pick = int'($urandom_range(99));
        if (pick < 75 && lo <= hi)
            return 16'($urandom_range(hi, lo));
        if (pick < 85)
            return 16'($urandom_range(shadow_cfg.near_limit_ticks, 0));
        if (pick < 92)
            return 16'($urandom_range(65535, shadow_cfg.invalid_limit_ticks));
        return 16'($urandom);
    endfunction

    function automatic row_t sample_row(input logic [15:0] ticks, input logic missing);
        row_t r;
        r.kind    = ROW_SAMPLE;
        r.index   = CFG_SAMPLES;
        r.value   = ticks;
        r.missing = missing;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic row_t typed_row(input logic [15:0] ticks, input logic missing,
                                       input logic [15:0] mean, input logic has_valid,
                                       input logic [3:0] count, input drive_action_t action);
        row_t r;
        r                      = sample_row(ticks, missing);
        r.typed                = 1'b1;
        r.want.mean_ticks      = mean;
        r.want.group_has_valid = has_valid;
        r.want.edge_count      = count;
        r.want.drive_action    = action;
        return r;
    endfunction

    function automatic row_t write_row(input cfg_index_t idx, input logic [15:0] data);
        row_t r;
        r       = sample_row(data, 1'b0);
        r.kind  = ROW_WRITE;
        r.index = idx;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks. Each leaves its valid high after the transaction; the next
    // call, or the caller, drops it, so a step never sees two assignments to it.
    // ------------------------------------------------------------------

    // Offer one sample, idling first at the current rate, and predict on acceptance.
    task automatic send_sample(input logic [15:0] ticks, input logic missing,
                               input logic typed, input decision_t want);
        decision_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.echo_ticks   <= ticks;
        sample_ch.echo_missing <= missing;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        if (average_echo(ticks, missing, predicted))
            pending_decisions.push_back(typed ? want : predicted);
    endtask

    // Hold samples back until every owed decision has come out, then let the back end
    // settle: a sample that closes no group may still be in flight.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register and mirror it once the transaction completes.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_SAMPLES: shadow_cfg.samples_per_group   = data[3:0];
            CFG_NEAR:    shadow_cfg.near_limit_ticks    = data;
            CFG_INVALID: shadow_cfg.invalid_limit_ticks = data;
            CFG_TRIGGER: shadow_cfg.trigger_needed      = data[3:0];
            default: ;
        endcase
    endtask

    // Drain, then load a fresh random setting into all four registers. One time in
    // eight pick extremes. Unused upper data bits of the narrow registers stay random.
    task automatic program_random_settings();
        logic [15:0] group_word;
        logic [15:0] near_val;
        logic [15:0] invalid_val;
        logic [15:0] trigger_word;
        bit          extreme;
        extreme      = ($urandom_range(7) == 0);
        group_word   = 16'($urandom);
        trigger_word = 16'($urandom);
        if (extreme)
        begin
            case ($urandom_range(3))
                0: group_word[3:0] = 4'd0;
                1: group_word[3:0] = 4'd1;
                2: group_word[3:0] = 4'd8;
                default: group_word[3:0] = 4'd15;
            endcase
            near_val             = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            invalid_val          = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            trigger_word[3:0]    = $urandom_range(1) ? 4'd15 : 4'd0;
        end
        else
        begin
            group_word[3:0]   = 4'($urandom_range(6, 1));
            near_val          = 16'($urandom_range(30000, 0));
            // Mostly keep a band between the limits; now and then let it collapse.
            if ($urandom_range(7) == 0)
                invalid_val = 16'($urandom);
            else
                invalid_val = 16'(int'(near_val) + $urandom_range(65535 - int'(near_val), 1));
            trigger_word[3:0] = 4'($urandom_range(5, 1));
        end
        wait_for_drain();
        write_reg(CFG_SAMPLES, group_word);
        write_reg(CFG_NEAR, near_val);
        write_reg(CFG_INVALID, invalid_val);
        write_reg(CFG_TRIGGER, trigger_word);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall at the current rate and check every decision.
    // ------------------------------------------------------------------
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_results
        decision_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_decisions.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("%0t: decision with none owed: mean %0d valid %0b count %0d drive %0d",
                             $realtime, result_ch.mean_ticks, result_ch.group_has_valid,
                             result_ch.edge_count, result_ch.drive_action);
            end
            else
            begin
                want = pending_decisions.pop_front();
                if (result_ch.mean_ticks !== want.mean_ticks
                    || result_ch.group_has_valid !== want.group_has_valid
                    || result_ch.edge_count !== want.edge_count
                    || result_ch.drive_action !== want.drive_action)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: decision mismatch", $realtime);
                        $display("    expected mean %0d valid %0b count %0d drive %0d",
                                 want.mean_ticks, want.group_has_valid, want.edge_count,
                                 want.drive_action);
                        $display("    actual   mean %0d valid %0b count %0d drive %0d",
                                 result_ch.mean_ticks, result_ch.group_has_valid,
                                 result_ch.edge_count, result_ch.drive_action);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no channel completes a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
            || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        decision_t none;
        int        sent;
        bit        writing;

        // Drive every input to a known value and hold reset.
        rst_n                  <= 1'b0;
        sample_ch.valid        <= 1'b0;
        sample_ch.echo_ticks   <= '0;
        sample_ch.echo_missing <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= CFG_SAMPLES;
        cfg_ch.data            <= '0;

        send_idle_pct = 22;
        recv_idle_pct = 80;
        none          = '0;
        writing       = 1'b0;

        shadow_cfg.samples_per_group   = SAMPLES_RST;
        shadow_cfg.near_limit_ticks    = NEAR_RST;
        shadow_cfg.invalid_limit_ticks = INVALID_RST;
        shadow_cfg.trigger_needed      = TRIGGER_RST;
        group_pos   = '0;
        group_sum   = '0;
        group_valid = '0;
        edge_run    = '0;

        // Group of five under reset limits: zero ticks, saturated ticks (invalid), a
        // missing echo, a tick just under the invalid limit, an ordinary tick.
        stimulus_table.push_back(sample_row(16'd0, 1'b0));
        stimulus_table.push_back(sample_row(16'd65535, 1'b0));
        stimulus_table.push_back(sample_row(16'd1000, 1'b1));
        stimulus_table.push_back(sample_row(16'd58250, 1'b0));
        stimulus_table.push_back(sample_row(16'd2000, 1'b0));
        // Group size zero acts as one (upper data bits set and ignored); trigger zero
        // turns around on every edge group.
        stimulus_table.push_back(write_row(CFG_SAMPLES, 16'hFFF0));
        stimulus_table.push_back(write_row(CFG_TRIGGER, 16'h0000));
        stimulus_table.push_back(typed_row(16'd3000, 1'b0, 16'd3000, 1'b1, 4'd0, DRIVE_TURN));
        // No valid sample, then a zero tick: zero mean, forward drive.
        stimulus_table.push_back(typed_row(16'd65535, 1'b1, 16'd0, 1'b0, 4'd0, DRIVE_FORWARD));
        stimulus_table.push_back(typed_row(16'd0, 1'b0, 16'd0, 1'b1, 4'd0, DRIVE_FORWARD));
        // Highest trigger: one tick past the near limit keeps drive, the limit itself
        // is no edge.
        stimulus_table.push_back(write_row(CFG_TRIGGER, 16'h000F));
        stimulus_table.push_back(typed_row(16'd1458, 1'b0, 16'd1458, 1'b1, 4'd1, DRIVE_KEEP));
        stimulus_table.push_back(typed_row(16'd1457, 1'b0, 16'd1457, 1'b1, 4'd0, DRIVE_FORWARD));
        // Oversized group clamps to eight; widest limits; a saturated tick equals the
        // invalid limit and drops out, the other seven sit one below it.
        stimulus_table.push_back(write_row(CFG_SAMPLES, 16'h000F));
        stimulus_table.push_back(write_row(CFG_NEAR, 16'h0000));
        stimulus_table.push_back(write_row(CFG_INVALID, 16'hFFFF));
        stimulus_table.push_back(sample_row(16'd65535, 1'b0));
        repeat (6) stimulus_table.push_back(sample_row(16'd65534, 1'b0));
        stimulus_table.push_back(typed_row(16'd65534, 1'b0, 16'd65534, 1'b1, 4'd1, DRIVE_KEEP));
        // Lower the group size mid-group: the next sample closes the group.
        stimulus_table.push_back(sample_row(16'd10, 1'b0));
        stimulus_table.push_back(sample_row(16'd20, 1'b0));
        stimulus_table.push_back(sample_row(16'd30, 1'b1));
        stimulus_table.push_back(write_row(CFG_SAMPLES, 16'd2));
        stimulus_table.push_back(sample_row(16'd40, 1'b0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table. Drain before the first write of a run of writes; drop the
        // write valid once the next sample comes up.
        foreach (stimulus_table[r])
        begin
            if (stimulus_table[r].kind == ROW_WRITE)
            begin
                if (!writing)
                    wait_for_drain();
                writing = 1'b1;
                write_reg(stimulus_table[r].index, stimulus_table[r].value);
            end
            else
            begin
                if (writing)
                    cfg_ch.valid <= 1'b0;
                writing = 1'b0;
                send_sample(stimulus_table[r].value, stimulus_table[r].missing,
                            stimulus_table[r].typed, stimulus_table[r].want);
            end
        end
        if (writing)
            cfg_ch.valid <= 1'b0;

        // Random part in three idling modes: sender light and receiver heavy, the
        // reverse, then no idling. Each setting runs for a random stretch of samples;
        // a stretch that ends mid-group leaves the next setting to close it.
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 80;
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_MODE)
            begin
                program_random_settings();
                repeat ($urandom_range(60, 8))
                begin
                    send_sample(echo_for_setting(), ($urandom_range(99) < 8), 1'b0, none);
                    sent++;
                end
            end
        end

        // Collect the last decisions, let the block settle, then report.
        wait_for_drain();
        if (fault_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
